// ===== hdl/e2q_pkg.sv =====
package e2q_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int AtanEntries   = 24;
    localparam int NumIter = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
    // input fold, one stage per iteration, rounding, two products, round and saturate
    localparam int Latency = NumIter + 5;
    localparam int ZW = 34;
    localparam int XW = 33;
    localparam int TW = 18;
    localparam int PW = 36;
    localparam int SW = 50;

    localparam logic signed [ZW-1:0] GainQ30   = 34'sd652032874;
    localparam logic signed [ZW-1:0] HalfPiQ30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] PiQ30     = 34'sd3373259426;
    localparam logic signed [15:0]   UnitQ14   = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] angle_first;
        logic signed [15:0] angle_second;
        logic signed [15:0] angle_third;
    } t_angles;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_quat;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_rot;

    typedef struct packed {
        logic signed [TW-1:0] c;
        logic signed [TW-1:0] s;
    } t_cs;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        case (i)
            0: return 34'sd843314857;
            1: return 34'sd497837829;
            2: return 34'sd263043837;
            3: return 34'sd133525159;
            4: return 34'sd67021687;
            5: return 34'sd33543516;
            6: return 34'sd16775851;
            7: return 34'sd8388437;
            8: return 34'sd4194283;
            9: return 34'sd2097149;
            default: return ZW'(64'sd1 << (30 - i));
        endcase
    endfunction

endpackage

// ===== hdl/euler_to_quaternion.sv =====
// Euler angles to unit quaternion.
// Input: drive i_angles and pulse start; busy stays low, so a transaction is
// taken every cycle at which start is high.
// Output: o_quat is shown for one cycle with o_valid high.
// Pipeline: input fold, one register per CORDIC iteration, rounding,
// two product stages, round and saturate.
// Throughput: one transaction per cycle, set by the fully unrolled CORDIC
// pipeline with one iteration per stage.
// Reset clears the valid pipeline only; data in flight is dropped.
// The receiver cannot stall: every result is presented exactly once.
// Components are signed Q1.14 saturated to plus or minus one.
module euler_to_quaternion import e2q_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_angles i_angles,
    output logic    o_valid,
    output t_quat   o_quat
);
    t_cs cs_a, cs_b, cs_c;
    logic [Latency-1:0] r_vld;

    e2q_cordic u_cordic_a (.i_clk, .i_angle(i_angles.angle_first),  .o_cs(cs_a));
    e2q_cordic u_cordic_b (.i_clk, .i_angle(i_angles.angle_second), .o_cs(cs_b));
    e2q_cordic u_cordic_c (.i_clk, .i_angle(i_angles.angle_third),  .o_cs(cs_c));

    e2q_combine u_combine (
        .i_clk, .i_a(cs_a), .i_b(cs_b), .i_c(cs_c), .o_quat
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Latency-2:0], start};
        end
    end

    assign busy    = 1'b0;
    assign o_valid = r_vld[Latency-1];

`ifndef SYNTHESIS
    a_valid_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_vld[Latency-2]))
        else $error("valid pipeline broken");
    a_sat_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat.quat_x <= UnitQ14 && o_quat.quat_x >= -UnitQ14))
        else $error("quat_x out of range");
    a_sat_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat.quat_w <= UnitQ14 && o_quat.quat_w >= -UnitQ14))
        else $error("quat_w out of range");
`endif
endmodule

// ===== hdl/e2q_cordic.sv =====
module e2q_cordic import e2q_pkg::*; (
    input  logic               i_clk,
    input  logic signed [15:0] i_angle,
    output t_cs                o_cs
);
    t_rot r_stage [NumIter+1];
    t_rot n_init;
    logic signed [XW-1:0] n_xr;
    logic signed [XW-1:0] n_yr;
    t_cs  r_cs;

    always_comb begin
        n_init.x    = XW'(GainQ30);
        n_init.y    = '0;
        n_init.z    = ZW'(i_angle) <<< 16;
        n_init.flip = 1'b0;
        if (n_init.z > HalfPiQ30) begin
            n_init.z    = n_init.z - PiQ30;
            n_init.flip = 1'b1;
        end else if (n_init.z < -HalfPiQ30) begin
            n_init.z    = n_init.z + PiQ30;
            n_init.flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage[0] <= n_init;
    end

    for (genvar g = 0; g < NumIter; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            r_stage[g+1].flip <= r_stage[g].flip;
            if (r_stage[g].z >= 0) begin
                r_stage[g+1].x <= r_stage[g].x - (r_stage[g].y >>> g);
                r_stage[g+1].y <= r_stage[g].y + (r_stage[g].x >>> g);
                r_stage[g+1].z <= r_stage[g].z - atan_q30(g);
            end else begin
                r_stage[g+1].x <= r_stage[g].x + (r_stage[g].y >>> g);
                r_stage[g+1].y <= r_stage[g].y - (r_stage[g].x >>> g);
                r_stage[g+1].z <= r_stage[g].z + atan_q30(g);
            end
        end
    end

    // round Q.30 to Q.16, then undo the half-turn fold
    assign n_xr = (r_stage[NumIter].x + XW'(8192)) >>> 14;
    assign n_yr = (r_stage[NumIter].y + XW'(8192)) >>> 14;

    always_ff @(posedge i_clk) begin
        r_cs.c <= r_stage[NumIter].flip ? -TW'(n_xr) : TW'(n_xr);
        r_cs.s <= r_stage[NumIter].flip ? -TW'(n_yr) : TW'(n_yr);
    end

    assign o_cs = r_cs;
endmodule

// ===== hdl/e2q_combine.sv =====
module e2q_combine import e2q_pkg::*; (
    input  logic  i_clk,
    input  t_cs   i_a,
    input  t_cs   i_b,
    input  t_cs   i_c,
    output t_quat o_quat
);
    // pair products of angles a and b
    logic signed [PW-1:0] r_cc, r_ss, r_sc, r_cs;
    t_cs r_c1;
    logic signed [SW-1:0] r_p [8];
    logic signed [SW:0]   n_sum [4];
    logic signed [15:0]   r_q [4];

    always_ff @(posedge i_clk) begin
        r_cc <= PW'(i_a.c) * PW'(i_b.c);
        r_ss <= PW'(i_a.s) * PW'(i_b.s);
        r_sc <= PW'(i_a.s) * PW'(i_b.c);
        r_cs <= PW'(i_a.c) * PW'(i_b.s);
        r_c1 <= i_c;
    end

    always_ff @(posedge i_clk) begin
        r_p[0] <= SW'(r_sc) * SW'(r_c1.c);
        r_p[1] <= SW'(r_cs) * SW'(r_c1.s);
        r_p[2] <= SW'(r_cs) * SW'(r_c1.c);
        r_p[3] <= SW'(r_sc) * SW'(r_c1.s);
        r_p[4] <= SW'(r_cc) * SW'(r_c1.s);
        r_p[5] <= SW'(r_ss) * SW'(r_c1.c);
        r_p[6] <= SW'(r_cc) * SW'(r_c1.c);
        r_p[7] <= SW'(r_ss) * SW'(r_c1.s);
    end

    always_comb begin
        n_sum[0] = (SW+1)'(r_p[0]) - (SW+1)'(r_p[1]) + ((SW+1)'(1) <<< 33);
        n_sum[1] = (SW+1)'(r_p[2]) + (SW+1)'(r_p[3]) + ((SW+1)'(1) <<< 33);
        n_sum[2] = (SW+1)'(r_p[4]) - (SW+1)'(r_p[5]) + ((SW+1)'(1) <<< 33);
        n_sum[3] = (SW+1)'(r_p[6]) + (SW+1)'(r_p[7]) + ((SW+1)'(1) <<< 33);
    end

    for (genvar g = 0; g < 4; g++) begin : g_sat
        logic signed [SW-34:0] n_v;
        assign n_v = n_sum[g][SW:34];
        always_ff @(posedge i_clk) begin
            if (n_v > (SW-33)'(UnitQ14)) begin
                r_q[g] <= UnitQ14;
            end else if (n_v < -(SW-33)'(UnitQ14)) begin
                r_q[g] <= -UnitQ14;
            end else begin
                r_q[g] <= n_v[15:0];
            end
        end
    end

    assign o_quat.quat_x = r_q[0];
    assign o_quat.quat_y = r_q[1];
    assign o_quat.quat_z = r_q[2];
    assign o_quat.quat_w = r_q[3];
endmodule
